// ===== hdl/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBW_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SBW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sbw_pkg.sv =====
package sbw_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int ELEV_W        = 32;
    localparam int ROW_W         = 17;    // rows run to image_height + 1 during the flush
    localparam int IMG_W_W       = 12;
    localparam int IMG_H_W       = 16;
    localparam int EPS_W         = 31;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;

    localparam logic [IMG_W_W-1:0] IMG_W_RST = IMG_W_W'(1024);
    localparam logic [IMG_H_W-1:0] IMG_H_RST = IMG_H_W'(1024);
    localparam logic [EPS_W-1:0]   EPS_RST   = EPS_W'(256);

    localparam logic [ELEV_W-1:0] ELEV_MAX = {1'b0, {(ELEV_W-1){1'b1}}};
    localparam logic [ELEV_W-1:0] ELEV_MIN = {1'b1, {(ELEV_W-1){1'b0}}};

    // Result queue; must cover the three stages in flight plus a steady backlog.
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH    = 2'd0,
        CFG_IMAGE_HEIGHT   = 2'd1,
        CFG_EPSILON        = 2'd2,
        CFG_USE_NEIGHBOURS = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic              on_stream;
        logic              elevation_valid;
        logic [ELEV_W-1:0] elevation;
    } t_cell;

    // Where the centre pixel sits in the grid, worked out when its window closes.
    typedef struct packed {
        logic produce;
        logic last;
        logic top_ok;
        logic bottom_ok;
        logic left_ok;
        logic right_ok;
    } t_pos;

    typedef struct packed {
        logic              valid;
        logic              produce;
        logic              last;
        logic              burn;
        logic              pix_valid;
        logic [ELEV_W-1:0] z;
    } t_min;

endpackage

// ===== hdl/sbw_line_buffer.sv =====
module sbw_line_buffer #(
    parameter int  MAX_WIDTH = sbw_pkg::MAX_WIDTH_DEF,
    localparam int COL_W     = $clog2(MAX_WIDTH)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [COL_W-1:0]   i_col,
    input  sbw_pkg::t_cell     i_cell,
    output logic               o_valid,
    output sbw_pkg::t_cell     o_top,
    output sbw_pkg::t_cell     o_mid,
    output sbw_pkg::t_cell     o_cell
);

    typedef struct packed {
        sbw_pkg::t_cell top;
        sbw_pkg::t_cell mid;
    } t_column;

    t_column          r_mem [MAX_WIDTH];
    t_column          r_rd;
    t_column          r_fwd_word;
    logic             r_fwd;
    logic             r_valid;
    logic [COL_W-1:0] r_col;
    sbw_pkg::t_cell   r_cell;

    t_column rd_word;
    t_column wr_word;

    // Single-column rows revisit the same address on back-to-back transfers.
    assign rd_word = r_fwd ? r_fwd_word : r_rd;
    assign wr_word = '{top: rd_word.mid, mid: r_cell};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_fwd   <= 1'b0;
        end else begin
            r_valid <= i_push;
            r_fwd   <= i_push && r_valid && (i_col == r_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_col  <= i_col;
            r_cell <= i_cell;
            r_rd   <= r_mem[i_col];
        end
        r_fwd_word <= wr_word;
        if (r_valid) begin
            r_mem[r_col] <= wr_word;
        end
    end

    assign o_valid = r_valid;
    assign o_top   = rd_word.top;
    assign o_mid   = rd_word.mid;
    assign o_cell  = r_cell;

endmodule

// ===== hdl/sbw_window.sv =====
module sbw_window (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  sbw_pkg::t_cell i_top,
    input  sbw_pkg::t_cell i_mid,
    input  sbw_pkg::t_cell i_cell,
    input  sbw_pkg::t_pos  i_pos,
    input  logic           i_use_nb,
    output logic           o_b_valid,
    output sbw_pkg::t_min  o_min
);

    sbw_pkg::t_cell r_win [9];
    sbw_pkg::t_pos  r_b_pos;
    logic           r_b_valid;
    sbw_pkg::t_min  r_m;
    logic           r_m_valid;

    logic [sbw_pkg::ELEV_W-1:0] cand [9];
    logic [sbw_pkg::ELEV_W-1:0] l1 [4];
    logic [sbw_pkg::ELEV_W-1:0] l2 [2];
    logic [sbw_pkg::ELEV_W-1:0] l3;
    logic [sbw_pkg::ELEV_W-1:0] nb_min;
    logic                       burn;

    function automatic logic [sbw_pkg::ELEV_W-1:0] min2(
        input logic [sbw_pkg::ELEV_W-1:0] a,
        input logic [sbw_pkg::ELEV_W-1:0] b
    );
        return ($signed(a) < $signed(b)) ? a : b;
    endfunction

    // Skipped neighbours enter the tree as the largest elevation.
    function automatic logic [sbw_pkg::ELEV_W-1:0] pick(
        input sbw_pkg::t_cell nbr,
        input logic           ok,
        input logic           use_nb
    );
        return (use_nb && ok && nbr.elevation_valid && !nbr.on_stream) ?
               nbr.elevation : sbw_pkg::ELEV_MAX;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win     <= '{default: '0};
            r_b_valid <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_b_valid <= i_shift;
            r_m_valid <= r_b_valid;
            if (i_shift) begin
                r_win[0] <= r_win[1];
                r_win[1] <= r_win[2];
                r_win[2] <= i_top;
                r_win[3] <= r_win[4];
                r_win[4] <= r_win[5];
                r_win[5] <= i_mid;
                r_win[6] <= r_win[7];
                r_win[7] <= r_win[8];
                r_win[8] <= i_cell;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_b_pos <= i_pos;
        end
        r_m.valid     <= 1'b0;
        r_m.produce   <= r_b_pos.produce;
        r_m.last      <= r_b_pos.last;
        r_m.burn      <= burn;
        r_m.pix_valid <= r_win[4].elevation_valid;
        r_m.z         <= burn ? nb_min : r_win[4].elevation;
    end

    always_comb begin
        cand[0] = pick(r_win[0], r_b_pos.top_ok && r_b_pos.left_ok, i_use_nb);
        cand[1] = pick(r_win[1], r_b_pos.top_ok, i_use_nb);
        cand[2] = pick(r_win[2], r_b_pos.top_ok && r_b_pos.right_ok, i_use_nb);
        cand[3] = pick(r_win[3], r_b_pos.left_ok, i_use_nb);
        cand[4] = r_win[4].elevation;
        cand[5] = pick(r_win[5], r_b_pos.right_ok, i_use_nb);
        cand[6] = pick(r_win[6], r_b_pos.bottom_ok && r_b_pos.left_ok, i_use_nb);
        cand[7] = pick(r_win[7], r_b_pos.bottom_ok, i_use_nb);
        cand[8] = pick(r_win[8], r_b_pos.bottom_ok && r_b_pos.right_ok, i_use_nb);

        l1[0]  = min2(cand[0], cand[1]);
        l1[1]  = min2(cand[2], cand[3]);
        l1[2]  = min2(cand[5], cand[6]);
        l1[3]  = min2(cand[7], cand[8]);
        l2[0]  = min2(l1[0], l1[1]);
        l2[1]  = min2(l1[2], l1[3]);
        l3     = min2(l2[0], l2[1]);
        nb_min = min2(l3, cand[4]);

        burn = r_win[4].elevation_valid && r_win[4].on_stream;
    end

    always_comb begin
        o_min       = r_m;
        o_min.valid = r_m_valid;
    end

    assign o_b_valid = r_b_valid;

endmodule

// ===== hdl/sbw_burn_out.sv =====
module sbw_burn_out (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sbw_pkg::t_min                  i_min,
    input  logic [sbw_pkg::EPS_W-1:0]      i_eps,
    input  logic                           i_stall,
    output logic [sbw_pkg::FIFO_CNT_W-1:0] o_count,
    output logic                           o_valid,
    output logic signed [sbw_pkg::ELEV_W-1:0] o_burned_elevation,
    output logic                           o_result_valid,
    output logic                           o_last_of_frame
);

    typedef struct packed {
        logic [sbw_pkg::ELEV_W-1:0] elev;
        logic                       valid;
        logic                       last;
    } t_entry;

    t_entry                         r_q [sbw_pkg::FIFO_DEPTH];
    logic [sbw_pkg::FIFO_PTR_W-1:0] r_wr_ptr;
    logic [sbw_pkg::FIFO_PTR_W-1:0] r_rd_ptr;
    logic [sbw_pkg::FIFO_CNT_W-1:0] r_count;
    logic [sbw_pkg::FIFO_CNT_W-1:0] n_count;

    logic [sbw_pkg::ELEV_W:0]   diff;
    logic                       sat;
    logic [sbw_pkg::ELEV_W-1:0] burned;
    logic                       push;
    logic                       pop;

    function automatic logic [sbw_pkg::FIFO_PTR_W-1:0] next_ptr(
        input logic [sbw_pkg::FIFO_PTR_W-1:0] p
    );
        return (p == sbw_pkg::FIFO_PTR_W'(sbw_pkg::FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // epsilon is never negative, so only the low end can overflow
    assign diff   = {i_min.z[sbw_pkg::ELEV_W-1], i_min.z}
                  - {2'b00, i_eps};
    assign sat    = diff[sbw_pkg::ELEV_W] != diff[sbw_pkg::ELEV_W-1];
    assign burned = !i_min.burn ? i_min.z :
                    sat         ? sbw_pkg::ELEV_MIN : diff[sbw_pkg::ELEV_W-1:0];

    assign push    = i_min.valid && i_min.produce;
    assign pop     = o_valid && !i_stall;
    assign n_count = r_count + sbw_pkg::FIFO_CNT_W'(push) - sbw_pkg::FIFO_CNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= '{elev: burned, valid: i_min.pix_valid, last: i_min.last};
        end
    end

    assign o_count            = r_count;
    assign o_valid            = r_count != '0;
    assign o_burned_elevation = r_q[r_rd_ptr].elev;
    assign o_result_valid     = r_q[r_rd_ptr].valid;
    assign o_last_of_frame    = r_q[r_rd_ptr].last;

endmodule

// ===== hdl/stream_burn_window.sv =====
// Channel     Dir  Handshake                  Payload
// pixel in    in   i_valid / o_stall          i_elevation, i_elevation_valid, i_on_stream,
//                                             i_flush
// result out  out  o_valid / i_stall          o_burned_elevation, o_result_valid,
//                                             o_last_of_frame
// config      in   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One pixel per cycle sustained while o_stall is low. The result for the transfer that
// closes its window passes the line store read, window shift and neighbour minimum
// registers, then the epsilon subtract on the way into the result queue.
// The line store has one read and one write port, so each column is touched once a pixel.
// Synchronous active-low reset clears counters, window and result queue and loads the
// register defaults; the line store is not cleared.
// o_stall rises once queued results plus pixels in the three stages reach eight.
module stream_burn_window #(
    parameter int MAX_WIDTH = sbw_pkg::MAX_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [sbw_pkg::ELEV_W-1:0]   i_elevation,
    input  logic                                i_elevation_valid,
    input  logic                                i_on_stream,
    input  logic                                i_flush,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [sbw_pkg::ELEV_W-1:0]   o_burned_elevation,
    output logic                                o_result_valid,
    output logic                                o_last_of_frame,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sbw_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sbw_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WID_W  = $clog2(MAX_WIDTH + 1);
    localparam int PEND_W = $clog2(sbw_pkg::FIFO_DEPTH + 4);

    logic [sbw_pkg::IMG_W_W-1:0] r_image_width;
    logic [sbw_pkg::IMG_H_W-1:0] r_image_height;
    logic [sbw_pkg::EPS_W-1:0]   r_epsilon;
    logic                        r_use_neighbours;

    logic [COL_W-1:0]          r_col;
    logic [sbw_pkg::ROW_W-1:0] r_row;
    logic [COL_W-1:0]          n_col;
    logic [sbw_pkg::ROW_W-1:0] n_row;
    sbw_pkg::t_pos             r_a_pos;

    sbw_pkg::t_cfg_index       cfg_idx;
    logic                      cfg_we;
    logic                      cfg_restart;
    logic [WID_W-1:0]          eff_w;
    logic [sbw_pkg::ROW_W-1:0] eff_h;
    logic [WID_W-1:0]          col_inc;
    logic                      wrap;
    logic                      c_zero;
    logic                      accept;
    sbw_pkg::t_pos             pos;
    sbw_pkg::t_cell            in_cell;

    logic                           lb_valid;
    sbw_pkg::t_cell                 lb_top;
    logic                           win_b_valid;
    sbw_pkg::t_cell                 lb_mid;
    sbw_pkg::t_cell                 lb_cell;
    sbw_pkg::t_min                  win_min;
    logic [sbw_pkg::FIFO_CNT_W-1:0] q_count;
    logic [PEND_W-1:0]              pending;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign cfg_idx     = sbw_pkg::t_cfg_index'(i_cfg_index);
    assign cfg_restart = cfg_we && (cfg_idx == sbw_pkg::CFG_IMAGE_WIDTH ||
                                    cfg_idx == sbw_pkg::CFG_IMAGE_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width    <= sbw_pkg::IMG_W_RST;
            r_image_height   <= sbw_pkg::IMG_H_RST;
            r_epsilon        <= sbw_pkg::EPS_RST;
            r_use_neighbours <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_idx)
                sbw_pkg::CFG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg_data[sbw_pkg::IMG_W_W-1:0];
                end
                sbw_pkg::CFG_IMAGE_HEIGHT: begin
                    r_image_height <= i_cfg_data[sbw_pkg::IMG_H_W-1:0];
                end
                sbw_pkg::CFG_EPSILON: begin
                    r_epsilon <= i_cfg_data[sbw_pkg::EPS_W-1:0];
                end
                sbw_pkg::CFG_USE_NEIGHBOURS: begin
                    r_use_neighbours <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Zero reads as one; widths beyond the line store clip to it.
    always_comb begin
        if (r_image_width == '0) begin
            eff_w = WID_W'(1);
        end else if (32'(r_image_width) > 32'(MAX_WIDTH)) begin
            eff_w = WID_W'(MAX_WIDTH);
        end else begin
            eff_w = WID_W'(r_image_width);
        end
        eff_h = (r_image_height == '0) ? sbw_pkg::ROW_W'(1)
                                       : sbw_pkg::ROW_W'(r_image_height);
    end

    // The centre pixel lags the incoming one by a row and a column.
    always_comb begin
        c_zero      = r_col == '0;
        pos.produce = (r_row >= sbw_pkg::ROW_W'(2)) ||
                      (r_row == sbw_pkg::ROW_W'(1) && !c_zero);
        pos.last    = c_zero && (r_row == eff_h + sbw_pkg::ROW_W'(1));
        if (!c_zero) begin
            pos.left_ok   = r_col >= COL_W'(2);
            pos.right_ok  = 1'b1;
            pos.top_ok    = r_row >= sbw_pkg::ROW_W'(2);
            pos.bottom_ok = r_row < eff_h;
        end else begin
            // centre is the last column of the row before last
            pos.left_ok   = eff_w > WID_W'(1);
            pos.right_ok  = 1'b0;
            pos.top_ok    = r_row >= sbw_pkg::ROW_W'(3);
            pos.bottom_ok = r_row <= eff_h;
        end
    end

    assign accept  = i_valid && !o_stall;
    assign col_inc = WID_W'(r_col) + WID_W'(1);
    assign wrap    = col_inc == eff_w;

    always_comb begin
        if (pos.produce && pos.last) begin
            n_col = '0;
            n_row = '0;
        end else if (wrap) begin
            n_col = '0;
            n_row = r_row + sbw_pkg::ROW_W'(1);
        end else begin
            n_col = col_inc[COL_W-1:0];
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (cfg_restart) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_pos <= pos;
        end
    end

    // flush items enter as no-data, off-stream pixels
    always_comb begin
        in_cell.elevation       = i_elevation;
        in_cell.elevation_valid = i_elevation_valid && !i_flush;
        in_cell.on_stream       = i_on_stream && !i_flush;
    end

    sbw_line_buffer #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buffer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_col   (r_col),
        .i_cell  (in_cell),
        .o_valid (lb_valid),
        .o_top   (lb_top),
        .o_mid   (lb_mid),
        .o_cell  (lb_cell)
    );

    sbw_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_shift   (lb_valid),
        .i_top     (lb_top),
        .i_mid     (lb_mid),
        .i_cell    (lb_cell),
        .i_pos     (r_a_pos),
        .i_use_nb  (r_use_neighbours),
        .o_b_valid (win_b_valid),
        .o_min     (win_min)
    );

    sbw_burn_out u_burn_out (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_min              (win_min),
        .i_eps              (r_epsilon),
        .i_stall            (i_stall),
        .o_count            (q_count),
        .o_valid            (o_valid),
        .o_burned_elevation (o_burned_elevation),
        .o_result_valid     (o_result_valid),
        .o_last_of_frame    (o_last_of_frame)
    );

    // Credit check: every pixel in flight may still land in the queue.
    assign pending = PEND_W'(q_count) + PEND_W'(lb_valid) + PEND_W'(win_b_valid)
                   + PEND_W'(win_min.valid);
    assign o_stall = pending >= PEND_W'(sbw_pkg::FIFO_DEPTH);

endmodule

// ===== hdl/sbw_checker.sv =====
`include "assert_macros.svh"

module sbw_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_valid,
    input logic                               o_stall,
    input logic                               o_valid,
    input logic                               i_stall,
    input logic signed [sbw_pkg::ELEV_W-1:0]  o_burned_elevation,
    input logic                               o_result_valid,
    input logic                               o_last_of_frame,
    input logic                               i_cfg_valid,
    input logic                               o_cfg_ready
);

    // A held result keeps its payload until the transfer.
    `SBW_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_burned_elevation) && $stable(o_result_valid) && $stable(o_last_of_frame), "result changed while stalled")

    // From an empty queue a result shows once its pixel has cleared the pipeline.
    `SBW_ASSERT_IMPL(a_out_latency, i_clk, i_rst_n, $rose(o_valid), $past(i_valid && !o_stall, 4), "result appeared without a pixel four cycles earlier")

    // Only a new pixel adds to the credit count.
    `SBW_ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n, $rose(o_stall), $past(i_valid && !o_stall), "stall rose without an input transfer")

    `SBW_ASSERT_IMPL(a_cfg_ready, i_clk, i_rst_n, i_cfg_valid, o_cfg_ready, "register write held off")

endmodule

bind stream_burn_window sbw_checker u_sbw_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_valid            (i_valid),
    .o_stall            (o_stall),
    .o_valid            (o_valid),
    .i_stall            (i_stall),
    .o_burned_elevation (o_burned_elevation),
    .o_result_valid     (o_result_valid),
    .o_last_of_frame    (o_last_of_frame),
    .i_cfg_valid        (i_cfg_valid),
    .o_cfg_ready        (o_cfg_ready)
);
